@@ rtl/m61alu_pkg.sv @@
// Shared types, constants and helpers for the Mersenne-61 field arithmetic unit.
package m61alu_pkg;

    localparam int unsigned FIELD_W = 61;
    localparam int unsigned RAW_W   = 64;
    localparam int unsigned LIN_W   = FIELD_W + 1;
    localparam int unsigned SUM_W   = FIELD_W + 2;
    localparam int unsigned LO_W    = 31;
    localparam int unsigned HI_W    = FIELD_W - LO_W;
    localparam int unsigned STAGES  = 6;

    localparam logic [FIELD_W-1:0] FIELD_Q = {FIELD_W{1'b1}};
    // 2^64 is congruent to 8, so a negative raw integer needs q - 8 added.
    localparam logic [FIELD_W-1:0] Q_MINUS_8 = FIELD_Q - FIELD_W'(8);

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_NEG  = 3'd3,
        MODE_CONV = 3'd4
    } mode_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    // The all-ones pattern is q itself and is taken as zero.
    function automatic logic [FIELD_W-1:0] canon(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] r;
        r = (&v) ? '0 : v;
        return r;
    endfunction

endpackage

@@ rtl/mersenne61_field_alu.sv @@
// Top level of the arithmetic unit over the prime field modulo 2^61 - 1.
//
//   channel   direction   handshake               payload
//   input     in          in_valid / in_stall     mode, operand_a, operand_b, signed_value
//   output    out         out_valid / out_stall   result
//
// One transfer can enter in every cycle while in_stall is low. Each item passes in turn
// through the input register, four partial products of the 31-bit and 30-bit halves,
// two pairwise adds, the final add, the Mersenne fold and the conditional subtract.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
// A stall on the output freezes only the full stages; bubbles ahead of a stalled
// result still close up, so the input stalls only when all six stages hold items.
module mersenne61_field_alu
    import m61alu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               mode,
    input  logic [FIELD_W-1:0]       operand_a,
    input  logic [FIELD_W-1:0]       operand_b,
    input  logic signed [RAW_W-1:0]  signed_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [FIELD_W-1:0]       result
);

    // Stage valid bits, index 0 is the input register and index 5 the output register.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   adv;
    stage_en_t         en;

    logic [2*LO_W-1:0]  p00;
    logic [FIELD_W-1:0] p01;
    logic [FIELD_W-1:0] p10;
    logic [2*HI_W-1:0]  p11;
    logic [LIN_W-1:0]   lin;
    logic               is_mul;
    logic [LIN_W-1:0]   fold;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en.s1 = adv[0];
    assign en.s2 = adv[1];
    assign en.s3 = adv[2];
    assign en.s4 = adv[3];
    assign en.s5 = adv[4];
    assign en.s6 = adv[5];

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];

    m61alu_front u_front
    (
        .clk          (clk),
        .en           (en),
        .mode         (mode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .signed_value (signed_value),
        .p00          (p00),
        .p01          (p01),
        .p10          (p10),
        .p11          (p11),
        .lin          (lin),
        .is_mul       (is_mul)
    );

    m61alu_reduce u_reduce
    (
        .clk    (clk),
        .en     (en),
        .p00    (p00),
        .p01    (p01),
        .p10    (p10),
        .p11    (p11),
        .lin    (lin),
        .is_mul (is_mul),
        .fold   (fold),
        .result (result)
    );

    // A delivered result is always a canonical residue.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result != FIELD_Q))
    else $error("result is not a canonical residue");

    // The folded value never exceeds q + 3, so one subtract is enough.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> (fold <= ({1'b0, FIELD_Q} + LIN_W'(3))))
    else $error("folded value out of range for the final subtract");

    // The input may stall only when every stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
    else $error("input stalled while a pipeline stage is empty");

    // A stalled result stays in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result)))
    else $error("stalled result was lost or changed");

endmodule

@@ rtl/m61alu_front.sv @@
// Input capture, partial products of the multiply and the linear sum of the other modes.
module m61alu_front
    import m61alu_pkg::*;
(
    input  logic                      clk,
    input  stage_en_t                 en,
    input  logic [2:0]                mode,
    input  logic [FIELD_W-1:0]        operand_a,
    input  logic [FIELD_W-1:0]        operand_b,
    input  logic signed [RAW_W-1:0]   signed_value,
    output logic [2*LO_W-1:0]         p00,
    output logic [FIELD_W-1:0]        p01,
    output logic [FIELD_W-1:0]        p10,
    output logic [2*HI_W-1:0]         p11,
    output logic [LIN_W-1:0]          lin,
    output logic                      is_mul
);

    mode_t              mode_s1_reg;
    logic [FIELD_W-1:0] a_s1_reg;
    logic [FIELD_W-1:0] b_s1_reg;
    logic [RAW_W-1:0]   raw_s1_reg;

    logic [2*LO_W-1:0]  p00_reg, p00_next;
    logic [FIELD_W-1:0] p01_reg, p01_next;
    logic [FIELD_W-1:0] p10_reg, p10_next;
    logic [2*HI_W-1:0]  p11_reg, p11_next;
    logic [LIN_W-1:0]   lin_reg, lin_next;
    logic               mul_reg, mul_next;

    logic [LO_W-1:0]    a0, b0;
    logic [HI_W-1:0]    a1, b1;
    logic [FIELD_W-1:0] conv_bias;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            mode_s1_reg <= mode_t'(mode);
            a_s1_reg    <= canon(operand_a);
            b_s1_reg    <= canon(operand_b);
            raw_s1_reg  <= signed_value;
        end
    end

    assign a0 = a_s1_reg[LO_W-1:0];
    assign a1 = a_s1_reg[FIELD_W-1:LO_W];
    assign b0 = b_s1_reg[LO_W-1:0];
    assign b1 = b_s1_reg[FIELD_W-1:LO_W];

    assign p00_next = {{LO_W{1'b0}}, a0} * {{LO_W{1'b0}}, b0};
    assign p01_next = {{HI_W{1'b0}}, a0} * {{LO_W{1'b0}}, b1};
    assign p10_next = {{LO_W{1'b0}}, a1} * {{HI_W{1'b0}}, b0};
    assign p11_next = {{HI_W{1'b0}}, a1} * {{HI_W{1'b0}}, b1};

    assign conv_bias = raw_s1_reg[RAW_W-1] ? Q_MINUS_8 : '0;

    // For every mode but the multiply, the value below is congruent to the mode's result and stays under 2^62.
    always_comb
    begin
        mul_next = 1'b0;
        unique case (mode_s1_reg)
            MODE_ADD:  lin_next = {1'b0, a_s1_reg} + {1'b0, b_s1_reg};
            MODE_SUB:  lin_next = {1'b0, a_s1_reg} + {1'b0, ~b_s1_reg};
            MODE_MUL:
            begin
                lin_next = '0;
                mul_next = 1'b1;
            end
            MODE_NEG:  lin_next = {1'b0, ~a_s1_reg};
            MODE_CONV: lin_next = {1'b0, raw_s1_reg[FIELD_W-1:0]}
                                + {{(LIN_W-3){1'b0}}, raw_s1_reg[RAW_W-1:FIELD_W]}
                                + {1'b0, conv_bias};
            default:   lin_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            lin_reg <= lin_next;
            mul_reg <= mul_next;
        end
    end

    assign p00    = p00_reg;
    assign p01    = p01_reg;
    assign p10    = p10_reg;
    assign p11    = p11_reg;
    assign lin    = lin_reg;
    assign is_mul = mul_reg;

endmodule

@@ rtl/m61alu_reduce.sv @@
// Mersenne folding of the partial products or linear sum down to a canonical residue.
module m61alu_reduce
    import m61alu_pkg::*;
(
    input  logic                clk,
    input  stage_en_t           en,
    input  logic [2*LO_W-1:0]   p00,
    input  logic [FIELD_W-1:0]  p01,
    input  logic [FIELD_W-1:0]  p10,
    input  logic [2*HI_W-1:0]   p11,
    input  logic [LIN_W-1:0]    lin,
    input  logic                is_mul,
    output logic [LIN_W-1:0]    fold,
    output logic [FIELD_W-1:0]  result
);

    logic [FIELD_W-1:0] t1, t2, t3, t4;

    logic [LIN_W-1:0]   u_reg, u_next;
    logic [LIN_W-1:0]   w_reg, w_next;
    logic [LIN_W-1:0]   lin_s3_reg;
    logic               mul_s3_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LIN_W-1:0]   fold_reg, fold_next;
    logic [FIELD_W-1:0] result_reg, result_next;

    // A shift by 31 modulo q is a rotation of the 61-bit word, and 2^62 is congruent to 2.
    assign t1 = p00[FIELD_W-1:0];
    assign t2 = {p01[HI_W-1:0], p01[FIELD_W-1:HI_W]};
    assign t3 = {p10[HI_W-1:0], p10[FIELD_W-1:HI_W]};
    assign t4 = {p11, p00[2*LO_W-1]};

    assign u_next = {1'b0, t1} + {1'b0, t2};
    assign w_next = {1'b0, t3} + {1'b0, t4};

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            u_reg      <= u_next;
            w_reg      <= w_next;
            lin_s3_reg <= lin;
            mul_s3_reg <= is_mul;
        end
    end

    assign sum_next = mul_s3_reg ? ({1'b0, u_reg} + {1'b0, w_reg}) : {1'b0, lin_s3_reg};

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            sum_reg <= sum_next;
        end
    end

    assign fold_next = {1'b0, sum_reg[FIELD_W-1:0]}
                     + {{(LIN_W-2){1'b0}}, sum_reg[SUM_W-1:FIELD_W]};

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            fold_reg <= fold_next;
        end
    end

    // The folded value is at most q + 3, so one subtract makes it canonical.
    always_comb
    begin
        if (fold_reg >= {1'b0, FIELD_Q})
        begin
            result_next = FIELD_W'(fold_reg - {1'b0, FIELD_Q});
        end
        else
        begin
            result_next = fold_reg[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            result_reg <= result_next;
        end
    end

    assign fold   = fold_reg;
    assign result = result_reg;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Mersenne-61 field arithmetic unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import m61alu_pkg::*;

    // Mode codes that the unit does not define; they must return zero.
    localparam logic [2:0] MODE_SPARE_0 = 3'd5;
    localparam logic [2:0] MODE_SPARE_2 = 3'd7;

    localparam int unsigned RANDOM_REQUESTS = 800;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned MAX_REPORTS     = 10;

    // One operation offered to the unit. The drain flag holds the sender
    // back until every result already owed has come out.
    typedef struct {
        logic [2:0]         mode;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [RAW_W-1:0]   raw;
        bit                 drain;
    } alu_request_t;

    // A residue that the unit owes, together with the operation that
    // produced it, so that a mismatch can be traced back.
    typedef struct {
        logic [FIELD_W-1:0] residue;
        logic [2:0]         mode;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [RAW_W-1:0]   raw;
    } owed_residue_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [2:0]                mode = MODE_ADD;
    logic [FIELD_W-1:0]        operand_a = '0;
    logic [FIELD_W-1:0]        operand_b = '0;
    logic signed [RAW_W-1:0]   signed_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [FIELD_W-1:0]        result;

    alu_request_t  pending_requests[$];
    owed_residue_t owed_residues[$];
    alu_request_t  next_request;
    owed_residue_t oldest_owed;

    int unsigned cycle_count    = 0;
    int unsigned offered_count  = 0;
    int unsigned accepted_count = 0;
    int unsigned failure_count  = 0;
    bit          sender_enabled = 1'b0;

    // Sender burst shaping.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    // Receiver stall shaping.
    stall_style_t stall_style    = STALL_NONE;
    int unsigned  stall_run_left = 0;
    logic         stall_next;

    mersenne61_field_alu dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .signed_value (signed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result)
    );

    // A 10 ns clock, high and low for half a period each.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reduces lo + hi, where both are below 2^61, to a canonical residue.
    // One Mersenne fold brings the sum to at most q, and one
    // conditional subtract finishes the job.
    function automatic logic [FIELD_W-1:0] mersenne_fold(input logic [FIELD_W-1:0] lo,
                                                         input logic [FIELD_W-1:0] hi);
        logic [FIELD_W:0] sum;
        logic [FIELD_W:0] folded;
        sum    = {1'b0, lo} + {1'b0, hi};
        folded = {1'b0, sum[FIELD_W-1:0]} + {{FIELD_W{1'b0}}, sum[FIELD_W]};
        if (folded >= {1'b0, FIELD_Q})
            folded = folded - {1'b0, FIELD_Q};
        return folded[FIELD_W-1:0];
    endfunction

    // Predicts the residue the unit must return for one operation.
    function automatic logic [FIELD_W-1:0] field_residue(input logic [2:0] op,
                                                         input logic [FIELD_W-1:0] a_in,
                                                         input logic [FIELD_W-1:0] b_in,
                                                         input logic [RAW_W-1:0] raw);
        logic [FIELD_W-1:0]     x;
        logic [FIELD_W-1:0]     y;
        logic [FIELD_W-1:0]     r;
        logic [FIELD_W:0]       wide;
        logic [2*FIELD_W-1:0]   product;
        logic [RAW_W-1:0]       magnitude;
        // The all-ones pattern equals q and stands for zero.
        x = (a_in == FIELD_Q) ? '0 : a_in;
        y = (b_in == FIELD_Q) ? '0 : b_in;
        r = '0;
        case (op)
            MODE_ADD:
            begin
                wide = {1'b0, x} + {1'b0, y};
                if (wide >= {1'b0, FIELD_Q})
                    wide = wide - {1'b0, FIELD_Q};
                r = wide[FIELD_W-1:0];
            end
            MODE_SUB:
            begin
                if (x >= y)
                    wide = {1'b0, x} - {1'b0, y};
                else
                    wide = {1'b0, x} + {1'b0, FIELD_Q} - {1'b0, y};
                r = wide[FIELD_W-1:0];
            end
            MODE_MUL:
            begin
                product = {{FIELD_W{1'b0}}, x} * {{FIELD_W{1'b0}}, y};
                r = mersenne_fold(product[FIELD_W-1:0], product[2*FIELD_W-1:FIELD_W]);
            end
            MODE_NEG:
                r = (x == '0) ? '0 : FIELD_Q - x;
            MODE_CONV:
            begin
                // The most negative integer yields magnitude 2^63 here.
                magnitude = raw[RAW_W-1] ? (~raw + 1'b1) : raw;
                r = mersenne_fold(magnitude[FIELD_W-1:0],
                                  {{(2*FIELD_W-RAW_W){1'b0}}, magnitude[RAW_W-1:FIELD_W]});
                if (raw[RAW_W-1] && r != '0)
                    r = FIELD_Q - r;
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Random field operand, weighted toward the edges of the range.
    function automatic logic [FIELD_W-1:0] random_operand();
        logic [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = FIELD_Q;
            1: v = '0;
            2: v = FIELD_W'($urandom_range(0, 15));
            3: v = FIELD_Q - FIELD_W'($urandom_range(1, 16));
            default: v = FIELD_W'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    // Random 64-bit integer for conversion, with the boundaries mixed in.
    function automatic logic [RAW_W-1:0] random_raw();
        logic [RAW_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = {1'b1, {(RAW_W-1){1'b0}}};
            1: v = RAW_W'($urandom_range(0, 15));
            2: v = -RAW_W'($urandom_range(1, 16));
            3: v = {{(RAW_W-FIELD_W){1'b0}}, FIELD_Q} + RAW_W'($urandom_range(0, 3));
            4: v = -({{(RAW_W-FIELD_W){1'b0}}, FIELD_Q} + RAW_W'($urandom_range(0, 3)));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic queue_request(input logic [2:0] op,
                                 input logic [FIELD_W-1:0] a_in,
                                 input logic [FIELD_W-1:0] b_in,
                                 input logic [RAW_W-1:0] raw,
                                 input bit drain);
        alu_request_t req;
        req.mode  = op;
        req.a     = a_in;
        req.b     = b_in;
        req.raw   = raw;
        req.drain = drain;
        pending_requests.push_back(req);
    endtask

    // Sampling at the rising edge. Every input was set at the falling edge
    // before, so reading the ports here is free of ordering races. The
    // output is checked first so that a stray result cannot pair with an
    // expectation pushed in the same cycle.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (out_valid && !out_stall)
        begin
            if (owed_residues.size() == 0)
            begin
                failure_count = failure_count + 1;
                if (failure_count <= MAX_REPORTS)
                    $display("unexpected result transfer %h at cycle %0d", result, cycle_count);
            end
            else
            begin
                oldest_owed = owed_residues.pop_front();
                if (result !== oldest_owed.residue)
                begin
                    failure_count = failure_count + 1;
                    if (failure_count <= MAX_REPORTS)
                        $display("mismatch mode %0d a %h b %h raw %h: expected %h, got %h",
                                 oldest_owed.mode, oldest_owed.a, oldest_owed.b,
                                 oldest_owed.raw, oldest_owed.residue, result);
                end
            end
        end
        // An input transfer completes here; record what it must produce.
        if (in_valid && !in_stall)
        begin
            oldest_owed.mode    = mode;
            oldest_owed.a       = operand_a;
            oldest_owed.b       = operand_b;
            oldest_owed.raw     = signed_value;
            oldest_owed.residue = field_residue(mode, operand_a, operand_b, signed_value);
            owed_residues.push_back(oldest_owed);
            accepted_count = accepted_count + 1;
        end
    end

    // Driver. It runs at the falling edge, so the payload is stable well
    // ahead of the next rising edge. A new request is offered only once the
    // previous one has been transferred, so a stalled payload never moves
    // and valid never looks at the stall. Bursts of random length are
    // separated by random gaps; a gap of zero gives stretches of back-to-back
    // transfers.
    always @(negedge clk)
    begin
        if (sender_enabled && accepted_count == offered_count)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].drain && owed_residues.size() != 0))
            begin
                next_request = pending_requests.pop_front();
                mode         <= next_request.mode;
                operand_a    <= next_request.a;
                operand_b    <= next_request.b;
                signed_value <= next_request.raw;
                in_valid     <= 1'b1;
                offered_count = offered_count + 1;
                burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. The stall follows a style that is chosen anew at the end of
    // each random run: free running, coin flips, mostly stalled, or a fixed rhythm.
    always @(negedge clk)
    begin
        if (stall_run_left == 0)
        begin
            stall_style    = stall_style_t'($urandom_range(0, 3));
            stall_run_left = $urandom_range(20, 80);
        end
        stall_run_left = stall_run_left - 1;
        case (stall_style)
            STALL_NONE:     stall_next = 1'b0;
            STALL_COIN:     stall_next = ($urandom_range(0, 1) == 1);
            STALL_HEAVY:    stall_next = ($urandom_range(0, 7) != 0);
            default:        stall_next = (stall_run_left % 3 == 0);
        endcase
        out_stall <= stall_next;
    end

    // Watchdog: the run may not outlast the cycle limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("mersenne61_field_alu verification failed");
        $finish;
    end

    initial
    begin
        // Directed part: range edges, every mode and each special case.
        // Adds: zero, the largest sum, a wrap to zero, and q read as zero.
        queue_request(MODE_ADD, '0, '0, random_raw(), 1'b0);
        queue_request(MODE_ADD, FIELD_Q - 1'b1, FIELD_Q - 1'b1, random_raw(), 1'b0);
        queue_request(MODE_ADD, FIELD_Q - 1'b1, FIELD_W'(1), random_raw(), 1'b0);
        queue_request(MODE_ADD, FIELD_Q, FIELD_W'(5), random_raw(), 1'b0);
        // Subtracts: a borrow, equal operands, the largest result, q minus q.
        queue_request(MODE_SUB, '0, FIELD_W'(1), random_raw(), 1'b0);
        queue_request(MODE_SUB, FIELD_W'(5), FIELD_W'(5), random_raw(), 1'b0);
        queue_request(MODE_SUB, FIELD_Q - 1'b1, '0, random_raw(), 1'b0);
        queue_request(MODE_SUB, FIELD_Q, FIELD_Q, random_raw(), 1'b0);
        // Multiplies: (-1)*(-1), q times a value, zero, and a power of two wrap.
        queue_request(MODE_MUL, FIELD_Q - 1'b1, FIELD_Q - 1'b1, random_raw(), 1'b0);
        queue_request(MODE_MUL, FIELD_Q, FIELD_W'(3), random_raw(), 1'b0);
        queue_request(MODE_MUL, '0, FIELD_Q - 1'b1, random_raw(), 1'b0);
        queue_request(MODE_MUL, {1'b1, {(FIELD_W-1){1'b0}}}, FIELD_W'(2), random_raw(), 1'b0);
        // Negates: zero stays zero, one wraps to q - 1, and q counts as zero.
        queue_request(MODE_NEG, '0, random_operand(), random_raw(), 1'b0);
        queue_request(MODE_NEG, FIELD_W'(1), random_operand(), random_raw(), 1'b0);
        queue_request(MODE_NEG, FIELD_Q, random_operand(), random_raw(), 1'b0);
        // Conversions: zero, minus one, both integer extremes, and plus or minus q.
        queue_request(MODE_CONV, random_operand(), random_operand(), '0, 1'b0);
        queue_request(MODE_CONV, random_operand(), random_operand(), '1, 1'b0);
        queue_request(MODE_CONV, random_operand(), random_operand(),
                      {1'b1, {(RAW_W-1){1'b0}}}, 1'b0);
        queue_request(MODE_CONV, random_operand(), random_operand(),
                      {1'b0, {(RAW_W-1){1'b1}}}, 1'b0);
        queue_request(MODE_CONV, random_operand(), random_operand(),
                      {{(RAW_W-FIELD_W){1'b0}}, FIELD_Q}, 1'b0);
        queue_request(MODE_CONV, random_operand(), random_operand(),
                      -{{(RAW_W-FIELD_W){1'b0}}, FIELD_Q}, 1'b0);
        // Undefined modes must give zero whatever the operands are.
        queue_request(MODE_SPARE_0, random_operand(), random_operand(), random_raw(), 1'b0);
        queue_request(MODE_SPARE_2, FIELD_Q - 1'b1, FIELD_Q - 1'b1, '1, 1'b0);

        // Random part. The first request waits for the directed results to
        // drain, and now and then another one does the same.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                next_request.mode = 3'($urandom_range(MODE_SPARE_0, MODE_SPARE_2));
            else
                next_request.mode = 3'($urandom_range(MODE_ADD, MODE_CONV));
            queue_request(next_request.mode, random_operand(), random_operand(), random_raw(),
                          (i == 0) || ($urandom_range(0, 199) == 0));
        end

        // Reset is held low and released at a falling edge.
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        sender_enabled = 1'b1;

        // Wait for every request to be transferred, then for every owed
        // result, then a little longer to catch any stray output.
        while (pending_requests.size() != 0 || accepted_count != offered_count)
            @(posedge clk);
        while (owed_residues.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failure_count == 0)
            $display("mersenne61_field_alu verification clean");
        else
            $display("mersenne61_field_alu verification failed");
        $finish;
    end

endmodule
